### rtl/core/t2ndef_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// t2ndef_pkg: shared types and constants
// Widths, default sizes and the result record of the Type 2 tag page counter.
// ----------------------------------------------------------------------------
package t2ndef_pkg;

  localparam int DUMP_MAX_BYTES = 1024;
  localparam int PAGE_W = 15;
  localparam int CFG_W = 10;
  localparam logic [CFG_W-1:0] MAX_PAGE_RESET = 10'd255;

  typedef struct packed {
    logic              valid;
    logic [PAGE_W-1:0] pages;
  } rslt_t;

endpackage
`default_nettype wire

### rtl/core/t2ndef_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// t2ndef_parser: CC and TLV parse state
// Updates the parse state once per transferred byte and flags the one result
// of each buffer together with its page count.
// ----------------------------------------------------------------------------
module t2ndef_parser #(
  parameter int DumpMaxBytes = t2ndef_pkg::DUMP_MAX_BYTES
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          step,
  input  wire [7:0]                    tag_byte,
  input  wire                          end_of_buffer,
  input  wire [t2ndef_pkg::CFG_W-1:0]  max_page_index,
  output t2ndef_pkg::rslt_t            rslt
);

  localparam logic [2:0] PH_MAGIC  = 3'd0;
  localparam logic [2:0] PH_CC     = 3'd1;
  localparam logic [2:0] PH_TYPE   = 3'd2;
  localparam logic [2:0] PH_LEN    = 3'd3;
  localparam logic [2:0] PH_LEN_HI = 3'd4;
  localparam logic [2:0] PH_LEN_LO = 3'd5;
  localparam logic [2:0] PH_SKIP   = 3'd6;

  localparam logic [7:0] CC_MAGIC     = 8'hE1;
  localparam logic [7:0] TLV_NULL     = 8'h00;
  localparam logic [7:0] TLV_NDEF     = 8'h03;
  localparam logic [7:0] TLV_TERM     = 8'hFE;
  localparam logic [7:0] TLV_LONG_LEN = 8'hFF;
  localparam logic [16:0] DUMP_MAX    = 17'(DumpMaxBytes);

  localparam int PW = t2ndef_pkg::PAGE_W;

  logic [15:0] byte_position, byte_position_next;
  logic [2:0]  parse_phase, parse_phase_next;
  logic        tlv_is_ndef, tlv_is_ndef_next;
  logic [7:0]  len_high, len_high_next;
  logic [15:0] skip_remaining, skip_remaining_next;
  logic        answer_given, answer_given_next;

  logic        got;
  logic        len_done;
  logic [15:0] len_value;
  logic [15:0] skip_dec;
  logic [16:0] end_bytes;
  logic [16:0] need;
  logic [16:0] need_round;
  logic [16:0] term_sum;
  logic [PW-1:0] ndef_count;
  logic [PW-1:0] cap;
  logic [PW-1:0] ans;

  always_comb begin
    len_value  = (parse_phase == PH_LEN_LO) ? {len_high, tag_byte} : {8'd0, tag_byte};
    end_bytes  = {1'b0, byte_position} + 17'd1 + {1'b0, len_value};
    need       = (end_bytes > DUMP_MAX) ? DUMP_MAX : end_bytes;
    need_round = need + 17'd3;
    ndef_count = need_round[16:2];
    cap        = (max_page_index >= 10'd2) ?
                 PW'(max_page_index - 10'd2) : '0;
    term_sum   = {1'b0, byte_position} + 17'd4;
    skip_dec   = (skip_remaining != 16'd0) ? skip_remaining - 16'd1 : 16'd0;
  end

  always_comb begin
    byte_position_next  = byte_position;
    parse_phase_next    = parse_phase;
    tlv_is_ndef_next    = tlv_is_ndef;
    len_high_next       = len_high;
    skip_remaining_next = skip_remaining;
    answer_given_next   = answer_given;
    got                 = 1'b0;
    len_done            = 1'b0;
    ans                 = '0;

    if (!answer_given) begin
      case (parse_phase)
        PH_MAGIC: begin
          if (tag_byte != CC_MAGIC) got = 1'b1;
          else parse_phase_next = PH_CC;
        end
        PH_CC: begin
          if (byte_position >= 16'd3) parse_phase_next = PH_TYPE;
        end
        PH_TYPE: begin
          if (tag_byte == TLV_TERM) begin
            ans = term_sum[16:2];
            got = 1'b1;
          end else if (tag_byte != TLV_NULL) begin
            tlv_is_ndef_next = (tag_byte == TLV_NDEF);
            parse_phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          if (tag_byte == TLV_LONG_LEN) parse_phase_next = PH_LEN_HI;
          else len_done = 1'b1;
        end
        PH_LEN_HI: begin
          len_high_next    = tag_byte;
          parse_phase_next = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_done  = 1'b1;
        end
        PH_SKIP: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == 16'd0) parse_phase_next = PH_TYPE;
        end
        default: begin
          parse_phase_next = PH_TYPE;
        end
      endcase

      if (len_done) begin
        if (tlv_is_ndef) begin
          ans = (ndef_count > cap) ? cap : ndef_count;
          got = 1'b1;
        end else if (len_value == 16'd0) begin
          parse_phase_next = PH_TYPE;
        end else begin
          skip_remaining_next = len_value;
          parse_phase_next    = PH_SKIP;
        end
      end

      if (!got && end_of_buffer) begin
        ans = '0;
        got = 1'b1;
      end
      if (got) answer_given_next = 1'b1;
    end

    if (byte_position != 16'hFFFF) byte_position_next = byte_position + 16'd1;

    if (end_of_buffer) begin
      byte_position_next  = '0;
      parse_phase_next    = PH_MAGIC;
      tlv_is_ndef_next    = 1'b0;
      len_high_next       = '0;
      skip_remaining_next = '0;
      answer_given_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      parse_phase    <= PH_MAGIC;
      tlv_is_ndef    <= 1'b0;
      len_high       <= '0;
      skip_remaining <= '0;
      answer_given   <= 1'b0;
    end else if (step) begin
      byte_position  <= byte_position_next;
      parse_phase    <= parse_phase_next;
      tlv_is_ndef    <= tlv_is_ndef_next;
      len_high       <= len_high_next;
      skip_remaining <= skip_remaining_next;
      answer_given   <= answer_given_next;
    end
  end

  assign rslt.valid = step & got;
  assign rslt.pages = ans;

endmodule
`default_nettype wire

### rtl/core/t2ndef_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// t2ndef_out_reg: result register
// Holds one page count until the receiver takes it; frees itself on transfer.
// ----------------------------------------------------------------------------
module t2ndef_out_reg (
  input  wire                            clk,
  input  wire                            rst,
  input  t2ndef_pkg::rslt_t              rslt,
  output logic                           load_ok,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [t2ndef_pkg::PAGE_W-1:0]  pages_needed
);

  assign load_ok = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ok) begin
      out_valid <= rslt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && rslt.valid) begin
      pages_needed <= rslt.pages;
    end
  end

endmodule
`default_nettype wire

### rtl/core/type2_tag_ndef_page_count.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// type2_tag_ndef_page_count: NDEF page count of a Type 2 tag dump
// Feed the dump one byte per transfer on the input channel, starting at the
// first byte of the capability-container page; end_of_buffer marks the last
// byte. Each buffer yields exactly one pages_needed on the output channel,
// 0 when the CC magic is wrong or no terminator or NDEF TLV is found.
// The result appears in the cycle after the byte that decides it, from a
// result register. One byte is taken every cycle; in_ready drops only while
// a result sits in the register and out_ready is low, so a stalled receiver
// holds the input side off until it takes the result.
// Bytes after the answer are consumed without output until end_of_buffer,
// which rearms the parser for the next buffer.
// The config channel writes max_page_index (the NDEF count is capped at
// max_page_index - 2); cfg_ready is always high. Write it only when idle.
// Reset clears the parse state, empties the result register and sets
// max_page_index to 255.
// ----------------------------------------------------------------------------
module type2_tag_ndef_page_count #(
  parameter int DumpMaxBytes = t2ndef_pkg::DUMP_MAX_BYTES
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire [7:0]                      tag_byte,
  input  wire                            end_of_buffer,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [t2ndef_pkg::PAGE_W-1:0]  pages_needed,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [t2ndef_pkg::CFG_W-1:0]    cfg_data
);

  logic [t2ndef_pkg::CFG_W-1:0] max_page_index;
  t2ndef_pkg::rslt_t            rslt;
  logic                         load_ok;

  assign cfg_ready = 1'b1;
  assign in_ready  = load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_page_index <= t2ndef_pkg::MAX_PAGE_RESET;
    end else if (cfg_valid) begin
      max_page_index <= cfg_data;
    end
  end

  t2ndef_parser #(
    .DumpMaxBytes(DumpMaxBytes)
  ) u_parser (
    .clk            (clk),
    .rst            (rst),
    .step           (in_valid && load_ok),
    .tag_byte       (tag_byte),
    .end_of_buffer  (end_of_buffer),
    .max_page_index (max_page_index),
    .rslt           (rslt)
  );

  t2ndef_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .rslt         (rslt),
    .load_ok      (load_ok),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pages_needed (pages_needed)
  );

endmodule
`default_nettype wire

### rtl/core/t2ndef_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// t2ndef_checker: port-level checks
// Watches the top-level ports for handshake and result-range slips.
// ----------------------------------------------------------------------------
module t2ndef_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            in_ready,
  input wire                            out_valid,
  input wire                            out_ready,
  input wire [t2ndef_pkg::PAGE_W-1:0]   pages_needed,
  input wire                            cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pages_needed))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input held off with free result register");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pages_needed <= 15'd16384 && cfg_ready)
    else $error("page count out of range");

endmodule

bind type2_tag_ndef_page_count t2ndef_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .pages_needed (pages_needed),
  .cfg_ready    (cfg_ready)
);
`default_nettype wire

### tb/sv/t2ndef_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t2ndef_tb_pkg: tag dump codes for the page count testbench
// CC magic, TLV type codes and page geometry of a Type 2 tag, shared by the
// stimulus and the checker.
// ----------------------------------------------------------------------------
package t2ndef_tb_pkg;

  localparam logic [7:0] CC_MAGIC      = 8'hE1;
  localparam logic [7:0] TLV_NULL      = 8'h00;
  localparam logic [7:0] TLV_LOCK_CTRL = 8'h01;
  localparam logic [7:0] TLV_NDEF      = 8'h03;
  localparam logic [7:0] TLV_TERM      = 8'hFE;
  localparam logic [7:0] TLV_LONG_LEN  = 8'hFF;

  localparam int CC_BYTES   = 4;
  localparam int PAGE_BYTES = 4;
  localparam int CC_PAGE    = 3;

endpackage

### tb/sv/ndef_page_count_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndef_page_count_checker: prediction and compare for the page counter
// Watches the byte, result and config channels, tracks its own copy of the
// TLV parse and the page limit, queues the page count each buffer should
// yield and compares every result transfer against the oldest one.
// ----------------------------------------------------------------------------
module ndef_page_count_checker #(
  parameter int DumpMaxBytes = t2ndef_pkg::DUMP_MAX_BYTES
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  input  wire                            in_ready,
  input  wire [7:0]                      tag_byte,
  input  wire                            end_of_buffer,
  input  wire                            out_valid,
  input  wire                            out_ready,
  input  wire [t2ndef_pkg::PAGE_W-1:0]   pages_needed,
  input  wire                            cfg_valid,
  input  wire                            cfg_ready,
  input  wire [t2ndef_pkg::CFG_W-1:0]    cfg_data,
  output int                             fail_count,
  output int                             pending_results,
  output int                             results_checked
);

  import t2ndef_pkg::*;
  import t2ndef_tb_pkg::*;

  typedef enum logic [2:0] {
    PS_MAGIC,
    PS_CC,
    PS_TYPE,
    PS_LEN,
    PS_LEN_HI,
    PS_LEN_LO,
    PS_SKIP
  } parse_step_e;

  logic [CFG_W-1:0]  page_limit;
  logic [15:0]       byte_pos;
  parse_step_e       step;
  logic [7:0]        tlv_type;
  logic [7:0]        len_high;
  logic [15:0]       skip_left;
  logic              answered;
  logic [PAGE_W-1:0] pages_due[$];
  int                fails = 0;
  int                checked = 0;

  task automatic clear_parse();
    byte_pos  = '0;
    step      = PS_MAGIC;
    tlv_type  = '0;
    len_high  = '0;
    skip_left = '0;
    answered  = 1'b0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fails++;
  endtask

  task automatic finish_length(input int len, input int after, inout bit got, inout int ans);
    int need;
    int cap;
    if (tlv_type == TLV_NDEF) begin
      need = after + len;
      if (need > DumpMaxBytes) need = DumpMaxBytes;
      ans = (need + PAGE_BYTES - 1) / PAGE_BYTES;
      cap = (int'(page_limit) + 1 >= CC_PAGE) ? int'(page_limit) + 1 - CC_PAGE : 0;
      if (ans > cap) ans = cap;
      got = 1'b1;
    end else if (len == 0) begin
      step = PS_TYPE;
    end else begin
      skip_left = 16'(len);
      step = PS_SKIP;
    end
  endtask

  task automatic take_byte(input logic [7:0] b, input logic last);
    int p;
    int ans;
    bit got;
    p = byte_pos;
    ans = 0;
    got = 1'b0;
    if (!answered) begin
      case (step)
        PS_MAGIC: begin
          if (b != CC_MAGIC) got = 1'b1;
          else step = PS_CC;
        end
        PS_CC: begin
          if (p + 1 >= CC_BYTES) step = PS_TYPE;
        end
        PS_TYPE: begin
          if (b == TLV_TERM) begin
            ans = (p + PAGE_BYTES) / PAGE_BYTES;
            got = 1'b1;
          end else if (b != TLV_NULL) begin
            tlv_type = b;
            step = PS_LEN;
          end
        end
        PS_LEN: begin
          if (b == TLV_LONG_LEN) step = PS_LEN_HI;
          else finish_length(b, p + 1, got, ans);
        end
        PS_LEN_HI: begin
          len_high = b;
          step = PS_LEN_LO;
        end
        PS_LEN_LO: begin
          finish_length({len_high, b}, p + 1, got, ans);
        end
        PS_SKIP: begin
          if (skip_left > 0) skip_left--;
          if (skip_left == 0) step = PS_TYPE;
        end
        default: begin
          step = PS_TYPE;
        end
      endcase
      if (!got && last) begin
        ans = 0;
        got = 1'b1;
      end
      if (got) begin
        pages_due.push_back(PAGE_W'(ans));
        answered = 1'b1;
      end
    end
    if (byte_pos != 16'hFFFF) byte_pos++;
    if (last) clear_parse();
  endtask

  always @(posedge clk) begin : watch
    logic [PAGE_W-1:0] want;
    if (rst) begin
      page_limit = MAX_PAGE_RESET;
      clear_parse();
      pages_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) page_limit = cfg_data;
      if (out_valid && out_ready) begin
        checked++;
        if (pages_due.size() == 0) begin
          report_mismatch($sformatf("result pages_needed=%0d with none pending", pages_needed));
        end else begin
          want = pages_due.pop_front();
          if (pages_needed !== want)
            report_mismatch($sformatf("pages_needed=%0d, expected %0d", pages_needed, want));
        end
      end
      if (in_valid && in_ready) take_byte(tag_byte, end_of_buffer);
    end
    fail_count      <= fails;
    pending_results <= pages_due.size();
    results_checked <= checked;
  end

endmodule

### tb/sv/type2_tag_ndef_page_count_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// type2_tag_ndef_page_count_tb: regression for the Type 2 tag page counter
// Feeds directed and random tag dumps (well-formed TLV chains, truncated
// dumps and noise) under several page limits and flow patterns; the checker
// beside the block predicts and compares each page count.
// ----------------------------------------------------------------------------
module type2_tag_ndef_page_count_tb;

  import t2ndef_pkg::*;
  import t2ndef_tb_pkg::*;

  localparam int NumPhases  = 5;
  localparam int PhaseBytes = 390;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic [7:0]          tag_byte = '0;
  logic                end_of_buffer = 1'b0;
  logic                out_ready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CFG_W-1:0]    cfg_data = '0;
  wire                 in_ready;
  wire                 out_valid;
  wire                 cfg_ready;
  wire [PAGE_W-1:0]    pages_needed;

  int                  fail_count;
  int                  pending_results;
  int                  results_checked;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  int                  bytes_sent = 0;
  int                  buffers_sent = 0;
  logic [7:0]          dump_bytes[$];

  int                  idle_of[NumPhases]  = '{0, 80, 0, 33, 0};
  int                  stall_of[NumPhases] = '{0, 0, 80, 33, 0};

  type2_tag_ndef_page_count dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .tag_byte      (tag_byte),
    .end_of_buffer (end_of_buffer),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pages_needed  (pages_needed),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  ndef_page_count_checker chk (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .tag_byte        (tag_byte),
    .end_of_buffer   (end_of_buffer),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .pages_needed    (pages_needed),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    tag_byte      <= b;
    end_of_buffer <= last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_dump();
    for (int i = 0; i < dump_bytes.size(); i++)
      send_byte(dump_bytes[i], i == dump_bytes.size() - 1);
    buffers_sent++;
  endtask

  // hold the sender off until every pending page count has been taken
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_page_limit(input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic build_random_dump();
    int shape;
    int n;
    int len;
    logic [7:0] kind;
    dump_bytes.delete();
    shape = $urandom_range(9);
    if (shape == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) dump_bytes.push_back(8'($urandom_range(255)));
    end else begin
      dump_bytes.push_back(CC_MAGIC);
      repeat (3) dump_bytes.push_back(8'($urandom_range(255)));
      repeat ($urandom_range(3)) begin
        if ($urandom_range(2) == 0) begin
          repeat ($urandom_range(1, 3)) dump_bytes.push_back(TLV_NULL);
        end else begin
          do kind = 8'($urandom_range(255));
          while (kind == TLV_NULL || kind == TLV_NDEF || kind == TLV_TERM);
          dump_bytes.push_back(kind);
          if ($urandom_range(3) == 0) begin
            len = $urandom_range(255);
            dump_bytes.push_back(TLV_LONG_LEN);
            dump_bytes.push_back(8'h00);
            dump_bytes.push_back(8'(len));
          end else begin
            len = $urandom_range(12);
            dump_bytes.push_back(8'(len));
          end
          repeat (len) dump_bytes.push_back(8'($urandom_range(255)));
        end
      end
      case ($urandom_range(2))
        0: begin
          dump_bytes.push_back(TLV_TERM);
        end
        1: begin
          dump_bytes.push_back(TLV_NDEF);
          dump_bytes.push_back(8'($urandom_range(254)));
        end
        default: begin
          dump_bytes.push_back(TLV_NDEF);
          dump_bytes.push_back(TLV_LONG_LEN);
          dump_bytes.push_back(8'($urandom_range(255)));
          dump_bytes.push_back(8'($urandom_range(255)));
        end
      endcase
      repeat ($urandom_range(4)) dump_bytes.push_back(8'($urandom_range(255)));
      // cut the dump short at a random byte
      if (shape == 1) begin
        n = $urandom_range(1, dump_bytes.size());
        while (dump_bytes.size() > n) void'(dump_bytes.pop_back());
      end
    end
  endtask

  initial begin
    int start;
    int limit;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    dump_bytes = '{8'h00};
    send_dump();
    dump_bytes = '{CC_MAGIC};
    send_dump();
    dump_bytes = '{CC_MAGIC, 8'h10, 8'h3F, 8'h00, TLV_NULL, TLV_TERM};
    send_dump();
    dump_bytes = '{CC_MAGIC, 8'h10, 8'h3F, 8'h00, TLV_NDEF, TLV_LONG_LEN, 8'h01, 8'h00, 8'hAA};
    send_dump();
    dump_bytes = '{CC_MAGIC, 8'h10, 8'h3F, 8'h00, TLV_LOCK_CTRL, 8'h02, 8'h55, 8'hAA,
                   TLV_NDEF, 8'h05};
    send_dump();
    dump_bytes = '{CC_MAGIC, 8'h10, 8'h3F, 8'h00, TLV_NDEF, TLV_LONG_LEN};
    send_dump();

    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      case (ph)
        0: limit = 3;
        1: limit = 1023;
        2: limit = $urandom_range(3, 1023);
        3: limit = 255;
        default: limit = 1023;
      endcase
      write_page_limit(CFG_W'(limit));
      send_idle_pct  = idle_of[ph];
      recv_stall_pct = stall_of[ph];
      start = bytes_sent;
      while (bytes_sent - start < PhaseBytes) begin
        if ($urandom_range(24) == 0) settle();
        build_random_dump();
        send_dump();
      end
    end

    settle();
    repeat (8) @(posedge clk);
    $display("Covered %0d dumps, %0d bytes, %0d page counts checked,",
             buffers_sent, bytes_sent, results_checked);
    $display("over five phases of page limit with free, sender-gap, receiver-stall and mixed flow.");
    if (fail_count == 0 && pending_results == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### type2_tag_ndef_page_count.f
rtl/core/t2ndef_pkg.sv
rtl/core/t2ndef_parser.sv
rtl/core/t2ndef_out_reg.sv
rtl/core/type2_tag_ndef_page_count.sv
rtl/core/t2ndef_checker.sv
tb/sv/t2ndef_tb_pkg.sv
tb/sv/ndef_page_count_checker.sv
tb/sv/type2_tag_ndef_page_count_tb.sv
